[sv/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent from the next cycle on
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/glpf_pkg.sv]
// shared constants and controller/datapath interface types of the peak finder
package glpf_pkg;

	localparam int MAX_COLS   = 63;
	localparam int MAX_ROWS   = 1024;
	localparam int DATA_W     = 16;
	localparam int ROW_W      = 10;
	localparam int COL_W      = 6;
	localparam int ROWS_CFG_W = 11;
	localparam int CFG_W      = 11;
	localparam int IDX_W      = 1;
	localparam int NUM_BANKS  = 3;
	localparam int SEL_W      = 2;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [IDX_W-1:0] REG_GRID_COLS = 1'b1;

	// commands from the controller
	typedef struct packed {
		logic accept;     // request taken this cycle
		logic rd_flush;   // issue bank reads for the last-row sweep
		logic flush_mode; // judgement belongs to the last-row sweep
		logic advance;    // judgement is done, move on
		logic finish;     // release held result as last of run
	} glpf_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic peak;
		logic pend_valid;
		logic out_free;
		logic grid_end;
		logic last_k;
	} glpf_sts_t;

endpackage

[sv/glpf_ram.sv]
// generic row buffer: one write port, two registered read ports
module glpf_ram #(
	parameter int DEPTH = 63,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [WIDTH-1:0] wdata,
	input  logic                    re_a,
	input  logic [AW-1:0]           raddr_a,
	input  logic                    re_b,
	input  logic [AW-1:0]           raddr_b,
	output logic signed [WIDTH-1:0] rdata_a,
	output logic signed [WIDTH-1:0] rdata_b
);

	logic signed [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we && ({1'b0, waddr} < (AW+1)'(DEPTH))) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re_a) begin
			rdata_a <= ({1'b0, raddr_a} < (AW+1)'(DEPTH)) ? mem[raddr_a] : '0;
		end
		if (re_b) begin
			rdata_b <= ({1'b0, raddr_b} < (AW+1)'(DEPTH)) ? mem[raddr_b] : '0;
		end
	end

endmodule

[sv/glpf_dp.sv]
// datapath: row buffers, position counters, neighbour compare and result registers
module glpf_dp import glpf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic signed [DATA_W-1:0] sample,
	input  logic                     out_ready,
	input  glpf_cmd_t                cmd,
	output glpf_sts_t                sts,
	output logic                     out_valid,
	output logic [ROW_W-1:0]         peak_row,
	output logic [COL_W-1:0]         peak_col,
	output logic                     last_of_run
);

	logic [ROWS_CFG_W-1:0] rows_cfg_q;
	logic [COL_W-1:0]      cols_cfg_q;
	logic [ROWS_CFG_W-1:0] eff_rows;
	logic [COL_W-1:0]      eff_cols;

	logic [ROW_W-1:0] row_pos_q;
	logic [COL_W-1:0] col_pos_q;
	logic [ROWS_CFG_W-1:0] row_inc;
	logic [COL_W:0]        col_inc;
	logic row_end_now, grid_end_now;

	logic signed [DATA_W-1:0] s_q;
	logic [ROW_W-1:0] r_q;
	logic [COL_W-1:0] c_q;
	logic [COL_W-1:0] k_q;
	logic row_end_q, grid_end_q;
	logic signed [DATA_W-1:0] left_q;

	logic [SEL_W-1:0] cur_sel_q, new_sel_q, old_sel_q;
	logic [SEL_W-1:0] p_sel, q_sel, p_sel_q, q_sel_q;
	logic             rd_en;
	logic [COL_W-1:0] rd_addr;
	logic signed [DATA_W-1:0] rd_a [NUM_BANKS];
	logic signed [DATA_W-1:0] rd_b [NUM_BANKS];
	logic signed [DATA_W-1:0] p_a, p_b, q_a;

	logic signed [DATA_W-1:0] v, up, dn, lf, rt;
	logic judge_en, peak;
	logic [ROW_W-1:0] cand_row;
	logic [COL_W-1:0] cand_col;
	logic [COL_W:0]   c_q_inc, k_q_inc;

	logic             pend_valid_q;
	logic [ROW_W-1:0] pend_row_q;
	logic [COL_W-1:0] pend_col_q;
	logic             out_valid_q, out_last_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_free, take, load_mid, load_last;

	// configuration registers with their clamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= ROWS_CFG_W'(1);
			cols_cfg_q <= COL_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_ROWS: rows_cfg_q <= cfg_data;
				REG_GRID_COLS: cols_cfg_q <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_rows = (rows_cfg_q == '0) ? ROWS_CFG_W'(1) :
		(rows_cfg_q > ROWS_CFG_W'(MAX_ROWS)) ? ROWS_CFG_W'(MAX_ROWS) : rows_cfg_q;
	assign eff_cols = (cols_cfg_q == '0) ? COL_W'(1) :
		({1'b0, cols_cfg_q} > (COL_W+1)'(MAX_COLS)) ? COL_W'(MAX_COLS) : cols_cfg_q;

	// position of the next request
	assign row_inc      = {1'b0, row_pos_q} + 1'b1;
	assign col_inc      = {1'b0, col_pos_q} + 1'b1;
	assign row_end_now  = col_inc >= {1'b0, eff_cols};
	assign grid_end_now = row_end_now && (row_inc >= eff_rows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q <= '0;
			col_pos_q <= '0;
		end else if (cmd.accept) begin
			if (row_end_now) begin
				col_pos_q <= '0;
				row_pos_q <= grid_end_now ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_pos_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// captured request and sweep counter
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			s_q        <= sample;
			r_q        <= row_pos_q;
			c_q        <= col_pos_q;
			row_end_q  <= row_end_now;
			grid_end_q <= grid_end_now;
			k_q        <= '0;
		end else if (cmd.advance && cmd.flush_mode) begin
			k_q <= k_q + 1'b1;
		end
		if (cmd.advance) begin
			left_q <= p_a;
		end
	end

	// rotating roles of the three row buffers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sel_q <= SEL_W'(0);
			new_sel_q <= SEL_W'(1);
			old_sel_q <= SEL_W'(2);
		end else if (cmd.finish && row_end_q) begin
			old_sel_q <= new_sel_q;
			new_sel_q <= cur_sel_q;
			cur_sel_q <= old_sel_q;
		end
	end

	// middle row is read at two columns, the row above at one
	assign rd_en   = cmd.accept || cmd.rd_flush;
	assign rd_addr = cmd.accept ? col_pos_q : k_q;
	assign p_sel   = cmd.accept ? new_sel_q : cur_sel_q;
	assign q_sel   = cmd.accept ? old_sel_q : new_sel_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			p_sel_q <= p_sel;
			q_sel_q <= q_sel;
		end
	end

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		glpf_ram #(.DEPTH(MAX_COLS), .WIDTH(DATA_W)) u_ram (
			.clk     (clk),
			.we      (cmd.accept && (cur_sel_q == SEL_W'(b))),
			.waddr   (col_pos_q),
			.wdata   (sample),
			.re_a    (rd_en && ((p_sel == SEL_W'(b)) || (q_sel == SEL_W'(b)))),
			.raddr_a (rd_addr),
			.re_b    (rd_en && (p_sel == SEL_W'(b))),
			.raddr_b (rd_addr + 1'b1),
			.rdata_a (rd_a[b]),
			.rdata_b (rd_b[b])
		);
	end

	assign p_a = rd_a[p_sel_q];
	assign p_b = rd_b[p_sel_q];
	assign q_a = rd_a[q_sel_q];

	// four-neighbour judgement, outside cells count as zero
	assign c_q_inc = {1'b0, c_q} + 1'b1;
	assign k_q_inc = {1'b0, k_q} + 1'b1;

	always_comb begin
		v = p_a;
		if (cmd.flush_mode) begin
			judge_en = 1'b1;
			up       = (r_q != '0) ? q_a : '0;
			dn       = '0;
			lf       = (k_q != '0) ? left_q : '0;
			rt       = (k_q_inc < {1'b0, eff_cols}) ? p_b : '0;
			cand_row = r_q;
			cand_col = k_q;
		end else begin
			judge_en = (r_q != '0);
			up       = (r_q > ROW_W'(1)) ? q_a : '0;
			dn       = s_q;
			lf       = (c_q != '0) ? left_q : '0;
			rt       = (c_q_inc < {1'b0, eff_cols}) ? p_b : '0;
			cand_row = r_q - 1'b1;
			cand_col = c_q;
		end
	end

	assign peak = judge_en && (v >= up) && (v >= dn) && (v >= lf) && (v >= rt);

	// one result is held back until it is known whether another follows
	assign out_free  = !out_valid_q || out_ready;
	assign take      = cmd.advance && peak;
	assign load_mid  = take && pend_valid_q;
	assign load_last = cmd.finish && pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				pend_valid_q <= 1'b1;
			end else if (load_last) begin
				pend_valid_q <= 1'b0;
			end
			if (load_mid || load_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_row_q <= cand_row;
			pend_col_q <= cand_col;
		end
		if (load_mid || load_last) begin
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_last_q <= load_last;
		end
	end

	assign sts.peak       = peak;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;
	assign sts.grid_end   = grid_end_q;
	assign sts.last_k     = k_q_inc >= {1'b0, eff_cols};

	assign out_valid   = out_valid_q;
	assign peak_row    = out_row_q;
	assign peak_col    = out_col_q;
	assign last_of_run = out_last_q;

endmodule

[sv/glpf_ctrl.sv]
// controller: sequences request intake, judgement, last-row sweep and release
module glpf_ctrl import glpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  glpf_sts_t sts,
	output logic      in_ready,
	output glpf_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_FL_RD,
		S_FL_CHK,
		S_FIN
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   checking;

	assign checking       = (state_q == S_CHK) || (state_q == S_FL_CHK);
	assign cmd.accept     = in_valid && in_ready_q;
	assign cmd.rd_flush   = (state_q == S_FL_RD);
	assign cmd.flush_mode = (state_q == S_FL_CHK);
	assign cmd.advance    = checking && (!sts.peak || !sts.pend_valid || sts.out_free);
	assign cmd.finish     = (state_q == S_FIN) && (!sts.pend_valid || sts.out_free);
	assign in_ready       = in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						state_q    <= S_CHK;
						in_ready_q <= 1'b0;
					end
				end
				S_CHK: begin
					if (cmd.advance) begin
						state_q <= sts.grid_end ? S_FL_RD : S_FIN;
					end
				end
				S_FL_RD: begin
					state_q <= S_FL_CHK;
				end
				S_FL_CHK: begin
					if (cmd.advance) begin
						state_q <= sts.last_k ? S_FIN : S_FL_RD;
					end
				end
				S_FIN: begin
					if (cmd.finish) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

[sv/grid_local_peak_finder.sv]
// top level of the four-neighbour grid peak finder
//
// usage
// - input channel in_valid/in_ready carries one signed sample per request,
//   grid in raster order; grid_rows and grid_cols are set through the
//   cfg_we/cfg_index/cfg_data write port while the block is idle
// - output channel out_valid/out_ready carries peak_row, peak_col and
//   last_of_run; cell (r-1, c) is judged by sample (r, c), and the final
//   sample of a grid also judges the whole last row
// - one sample walks intake with the row buffer write and reads, a compare
//   step and a release step; the block takes no new sample before the last
//   one is released, as the controller walks these steps against the registered
//   read ports of the row buffers
// - the final sample adds a last-row sweep, in which each column needs its
//   own buffer read before it is compared
// - a peak is held back until the next peak or the release step so that
//   last_of_run is known, then moves to the output register once that is free
// - a stalled receiver holds the output register and the controller waits,
//   so in_ready stays low until every result of the request has been queued
// - reset clears position, buffer roles and result flags; row buffers are
//   not cleared and are only read where written earlier in the same grid
module grid_local_peak_finder import glpf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ROW_W-1:0]         peak_row,
	output logic [COL_W-1:0]         peak_col,
	output logic                     last_of_run
);

	// command and status between sequencer and datapath
	glpf_cmd_t cmd;
	glpf_sts_t sts;

	glpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// row buffers, compare logic and the output register
	glpf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.peak_row    (peak_row),
		.peak_col    (peak_col),
		.last_of_run (last_of_run)
	);

endmodule

[sv/glpf_checker.sv]
// port-level checker for the peak finder and its bind
`include "assert_macros.svh"

module glpf_checker import glpf_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic [IDX_W-1:0]         cfg_index,
	input logic [CFG_W-1:0]         cfg_data,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic signed [DATA_W-1:0] sample,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [ROW_W-1:0]         peak_row,
	input logic [COL_W-1:0]         peak_col,
	input logic                     last_of_run
);

	// a stalled result keeps its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(peak_row) && $stable(peak_col) && $stable(last_of_run))

	// a taken request keeps the intake closed for the compare and release steps
	`ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready ##1 !in_ready)

	// leaving reset the block is open for requests with nothing pending
	`ASSERT_NOW(a_reset_state, clk, arst_n, $rose(arst_n), in_ready && !out_valid)

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (.*);

[tb/grid_local_peak_finder_test.sv]
// self-checking testbench for the four-neighbour grid peak finder
module grid_local_peak_finder_test import glpf_pkg::*;;

	// wait after the last peak before any register write, long enough for a
	// full last-row sweep of the widest grid that finds nothing
	localparam int SETTLE_CYCLES = 160;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 220;

	// what the stimulus plan asks the driver to do next
	typedef enum logic [1:0] {
		STEP_SAMPLE,
		STEP_CONFIG,
		STEP_SETTLE
	} step_kind_t;

	// how the sample values of a grid are drawn
	typedef enum logic [1:0] {
		VAL_WIDE,
		VAL_NARROW,
		VAL_EXTREME,
		VAL_NEGATIVE
	} value_style_t;

	typedef struct packed {
		step_kind_t        kind;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
	} plan_step_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} peak_t;

	typedef logic signed [DATA_W-1:0] line_t [MAX_COLS];

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [ROW_W-1:0]         peak_row;
	logic [COL_W-1:0]         peak_col;
	logic                     last_of_run;

	plan_step_t plan[$];
	peak_t      peaks_due[$];
	int         mismatches = 0;
	int         cycle_count = 0;

	// predictor copy of the block: three row buffers, scan position, registers
	line_t                 row_prev2, row_prev, row_live;
	logic [ROW_W-1:0]      pos_row = '0;
	logic [COL_W-1:0]      pos_col = '0;
	logic [ROWS_CFG_W-1:0] set_rows = 11'd1;
	logic [COL_W-1:0]      set_cols = 6'd1;

	// driver and monitor pacing
	int send_gap = 0;
	int take_stall = 0;
	int settle_left = SETTLE_CYCLES;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	grid_local_peak_finder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.peak_row   (peak_row),
		.peak_col   (peak_col),
		.last_of_run(last_of_run)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// a cell is a peak when it is no smaller than any of its four neighbours,
	// cells outside the grid reading as zero
	function automatic bit cell_peaks(input line_t up, input line_t mid, input line_t down,
			input bit has_up, input bit has_down, input int c, input int cols);
		int v, u, d, l, r;
		v = mid[c];
		u = 0;
		d = 0;
		l = 0;
		r = 0;
		if (has_up) begin
			u = up[c];
		end
		if (has_down) begin
			d = down[c];
		end
		if (c > 0) begin
			l = mid[c-1];
		end
		if (c + 1 < cols) begin
			r = mid[c+1];
		end
		return v >= u && v >= d && v >= l && v >= r;
	endfunction

	function automatic int live_rows();
		if (set_rows == 0) begin
			return 1;
		end
		return (set_rows > MAX_ROWS) ? MAX_ROWS : int'(set_rows);
	endfunction

	function automatic int live_cols();
		if (set_cols == 0) begin
			return 1;
		end
		return (set_cols > MAX_COLS) ? MAX_COLS : int'(set_cols);
	endfunction

	// one accepted sample: judge the cell one row up, and on the last sample of
	// the grid sweep the whole last row as well
	task automatic predict_peaks(input logic signed [DATA_W-1:0] s);
		int    rows, cols, r, c;
		bit    row_end, grid_end;
		peak_t batch[$];
		peak_t p;
		rows = live_rows();
		cols = live_cols();
		r = pos_row;
		c = pos_col;
		row_end = (c + 1 >= cols);
		grid_end = row_end && (r + 1 >= rows);
		row_live[c] = s;
		if (r >= 1 && cell_peaks(row_prev2, row_prev, row_live, r >= 2, 1'b1, c, cols)) begin
			p.row = ROW_W'(r - 1);
			p.col = COL_W'(c);
			p.last = 1'b0;
			batch.push_back(p);
		end
		if (grid_end) begin
			for (int k = 0; k < cols; k++) begin
				if (cell_peaks(row_prev, row_live, row_live, r >= 1, 1'b0, k, cols)) begin
					p.row = ROW_W'(r);
					p.col = COL_W'(k);
					p.last = 1'b0;
					batch.push_back(p);
				end
			end
		end
		if (batch.size() > 0) begin
			batch[batch.size()-1].last = 1'b1;
		end
		foreach (batch[i]) begin
			peaks_due.push_back(batch[i]);
		end
		if (row_end) begin
			row_prev2 = row_prev;
			row_prev = row_live;
			pos_col = '0;
			pos_row = grid_end ? '0 : ROW_W'(r + 1);
		end else begin
			pos_col = COL_W'(c + 1);
		end
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		if (idx == REG_GRID_ROWS) begin
			set_rows = value[ROWS_CFG_W-1:0];
		end else begin
			set_cols = value[COL_W-1:0];
		end
	endtask

	// input side: presents queued samples, register writes only once idle
	always @(posedge clk) begin
		plan_step_t head;
		logic       next_valid, next_we;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			next_valid = in_valid;
			next_we = 1'b0;
			if (in_valid && in_ready) begin
				predict_peaks(sample);
				next_valid = 1'b0;
				if ($urandom_range(0, 31) == 0) begin
					send_calm = !send_calm;
				end
				send_gap = send_calm ? 0 : $urandom_range(0, 5);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (plan.size() > 0) begin
					head = plan[0];
					case (head.kind)
						STEP_SAMPLE: begin
							next_valid = 1'b1;
							sample <= head.data;
							void'(plan.pop_front());
						end
						STEP_CONFIG: begin
							next_we = 1'b1;
							cfg_index <= head.index;
							cfg_data <= head.data[CFG_W-1:0];
							write_register(head.index, head.data[CFG_W-1:0]);
							void'(plan.pop_front());
						end
						default: begin
							// every peak in, then let a silent sweep run out
							if (peaks_due.size() != 0) begin
								settle_left = SETTLE_CYCLES;
							end else if (settle_left > 0) begin
								settle_left--;
							end else begin
								settle_left = SETTLE_CYCLES;
								void'(plan.pop_front());
							end
						end
					endcase
				end
			end
			in_valid <= next_valid;
			cfg_we <= next_we;
		end
	end

	// output side: random back-pressure, each peak against the oldest prediction
	always @(posedge clk) begin
		peak_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (peaks_due.size() == 0) begin
					$error("unexpected peak at row %0d col %0d", peak_row, peak_col);
					mismatches++;
				end else begin
					want = peaks_due.pop_front();
					if (peak_row !== want.row) begin
						$error("peak_row expected %0d got %0d", want.row, peak_row);
						mismatches++;
					end
					if (peak_col !== want.col) begin
						$error("peak_col expected %0d got %0d", want.col, peak_col);
						mismatches++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run expected %0d got %0d", want.last, last_of_run);
						mismatches++;
					end
				end
				if ($urandom_range(0, 31) == 0) begin
					take_calm = !take_calm;
				end
				take_stall = take_calm ? 0 : $urandom_range(0, 5);
			end else if (take_stall > 0) begin
				take_stall--;
			end
			out_ready <= (take_stall == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("grid_local_peak_finder: mismatch");
			$finish;
		end
	end

	task automatic push_sample(input logic [DATA_W-1:0] v);
		plan_step_t st;
		st.kind = STEP_SAMPLE;
		st.index = '0;
		st.data = v;
		plan.push_back(st);
	endtask

	// register writes always wait for the block to fall idle first
	task automatic reconfigure(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		plan_step_t st;
		st.kind = STEP_SETTLE;
		st.index = '0;
		st.data = '0;
		plan.push_back(st);
		st.kind = STEP_CONFIG;
		st.index = idx;
		st.data = DATA_W'(value);
		plan.push_back(st);
	endtask

	// unused upper bits of the column write carry noise that must be ignored
	task automatic set_grid(input int rows, input int cols);
		reconfigure(REG_GRID_ROWS, CFG_W'(rows));
		reconfigure(REG_GRID_COLS, {5'($urandom_range(0, 31)), 6'(cols)});
	endtask

	function automatic logic [DATA_W-1:0] draw_value(input value_style_t style);
		case (style)
			VAL_NARROW:   return DATA_W'($urandom_range(0, 6) - 3);
			VAL_NEGATIVE: return DATA_W'($urandom) | 16'h8000;
			VAL_EXTREME: begin
				case ($urandom_range(0, 4))
					0:       return 16'h8000;
					1:       return 16'hffff;
					2:       return 16'h0000;
					3:       return 16'h0001;
					default: return 16'h7fff;
				endcase
			end
			default:      return DATA_W'($urandom);
		endcase
	endfunction

	task automatic fill_grid(input int cells, input value_style_t style);
		for (int i = 0; i < cells; i++) begin
			push_sample(draw_value(style));
		end
	endtask

	initial begin
		int           random_items;
		int           rows, cols, eff_r, eff_c;
		value_style_t style;

		// 1x1 grid out of reset: a lone cell peaks unless it is negative
		push_sample(16'h0000);
		push_sample(16'hffff);
		push_sample(16'h7fff);

		// zero rows and columns both behave as one
		set_grid(0, 0);
		push_sample(16'h8000);
		push_sample(16'h0005);

		// 3x3 with extremes and plateaus, ties count as peaks
		set_grid(3, 3);
		push_sample(16'h7fff);
		push_sample(16'h8000);
		push_sample(16'h0000);
		push_sample(16'h0001);
		push_sample(16'h0001);
		push_sample(16'h0001);
		push_sample(16'hfffb);
		push_sample(16'h0007);
		push_sample(16'h0007);

		// row count lowered mid-grid: the current row becomes the last one
		set_grid(5, 2);
		push_sample(16'h0003);
		push_sample(16'h0009);
		push_sample(16'hfffe);
		push_sample(16'h0004);
		reconfigure(REG_GRID_ROWS, 11'd1);
		push_sample(16'h0002);
		push_sample(16'h0002);

		// column count lowered mid-row: the current column becomes the last one
		set_grid(2, 4);
		fill_grid(6, VAL_NARROW);
		reconfigure(REG_GRID_COLS, 11'd1);
		push_sample(16'h0001);

		// row count above the maximum on a thin grid, lowered before it ends
		set_grid(2047, 1);
		fill_grid(6, VAL_NARROW);
		reconfigure(REG_GRID_ROWS, 11'd1);
		push_sample(16'h0002);

		// random grids, widest first, mostly small
		set_grid(2, MAX_COLS);
		fill_grid(2 * MAX_COLS, VAL_WIDE);
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					cols = MAX_COLS;
					rows = $urandom_range(0, 2);
				end
				1: begin
					cols = 0;
					rows = $urandom_range(0, 6);
				end
				default: begin
					cols = $urandom_range(1, 10);
					rows = $urandom_range(0, 6);
				end
			endcase
			eff_r = (rows == 0) ? 1 : rows;
			eff_c = (cols == 0) ? 1 : cols;
			style = value_style_t'($urandom_range(0, 3));
			set_grid(rows, cols);
			fill_grid(eff_r * eff_c, style);
			random_items += eff_r * eff_c;
		end

		// closing settle: all peaks in and the block quiet
		reconfigure(REG_GRID_ROWS, 11'd1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (plan.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		if (peaks_due.size() != 0) begin
			$error("%0d predicted peaks never reported", peaks_due.size());
		end
		if (mismatches == 0 && peaks_due.size() == 0) begin
			$display("grid_local_peak_finder: match");
		end else begin
			$display("grid_local_peak_finder: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/glpf_pkg.sv
sv/glpf_ram.sv
sv/glpf_dp.sv
sv/glpf_ctrl.sv
sv/grid_local_peak_finder.sv
sv/glpf_checker.sv
tb/grid_local_peak_finder_test.sv
